// File: sv/serial_command_frame_receiver_assert.svh
// Assertion shorthands used by the receiver top module
`ifndef SERIAL_COMMAND_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SCFR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("serial_command_frame_receiver: check failed");

// Next-cycle implication, checked outside reset
`define SCFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("serial_command_frame_receiver: check failed");

`endif

// File: sv/scfr_pkg.sv
package scfr_pkg;

    // Default frame store depth
    localparam int BUF_DEPTH_DEF = 64;

    // Smallest legal length byte
    localparam logic [7:0] MIN_LEN_BYTE = 8'd2;

    // Register reset values
    localparam logic [7:0] HEAD_BYTE_RST   = 8'hFF;
    localparam logic [7:0] DEVICE_CODE_RST = 8'hFC;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_CODE = 1'b1;

    // Item modes
    localparam logic [1:0] MODE_RX      = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_BAD_HEAD = 3'd2;
    localparam logic [2:0] ST_BAD_ID   = 3'd3;
    localparam logic [2:0] ST_BAD_LEN  = 3'd4;
    localparam logic [2:0] ST_IGNORED  = 3'd5;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic [5:0] read_index;
    } scfr_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic       frame_ready;
        logic       checksum_ok;
        logic [7:0] cmd_code;
        logic [5:0] frame_length;
        logic [7:0] read_data;
    } scfr_out_t;

endpackage

// File: sv/scfr_store.sv
module scfr_store #(
    parameter int BUF_DEPTH = scfr_pkg::BUF_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         accept,
    input  logic                         wr_en,
    input  logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
    input  logic [7:0]                   wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(BUF_DEPTH)-1:0] rd_addr,
    output logic [7:0]                   rd_data
);
    import scfr_pkg::*;

    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] rd_data_reg;

    // Write received frame bytes
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register read data; zero for every other transaction
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end else if (accept) begin
            rd_data_reg <= '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/scfr_parser.sv
module scfr_parser #(
    parameter int BUF_DEPTH = scfr_pkg::BUF_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  scfr_pkg::scfr_in_t           in_item,
    input  logic [7:0]                   head_byte,
    input  logic [7:0]                   device_code,
    output scfr_pkg::scfr_out_t          result,
    output logic                         wr_en,
    output logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
    output logic [7:0]                   wr_data,
    output logic                         rd_en,
    output logic [$clog2(BUF_DEPTH)-1:0] rd_addr
);
    import scfr_pkg::*;

    localparam int PW = $clog2(BUF_DEPTH);
    localparam int IW = (PW > 6) ? PW : 6;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_ID,
        PH_LEN,
        PH_BODY
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [PW-1:0]   wpos_reg, wpos_next;
    logic [PW-1:0]   total_reg, total_next;
    logic            held_reg, held_next;
    logic [7:0]      sum_reg, sum_next;
    logic            match_reg, match_next;
    logic [7:0]      code_reg, code_next;
    logic [2:0]      status;
    logic            store_en;
    logic [8:0]      len_total;
    logic [PW-1:0]   pos_inc;
    logic [IW-1:0]   idx_wide;

    assign len_total = {1'b0, in_item.rx_byte} + 9'd2;
    assign pos_inc   = wpos_reg + PW'(1);

    // Advance the frame hunt for one transaction
    always_comb begin
        phase_next = phase_reg;
        wpos_next  = wpos_reg;
        total_next = total_reg;
        held_next  = held_reg;
        sum_next   = sum_reg;
        match_next = match_reg;
        code_next  = code_reg;
        status     = ST_OK;
        store_en   = 1'b0;
        wr_addr    = wpos_reg;
        case (in_item.mode)
            MODE_RX: begin
                if (held_reg) begin
                    status = ST_IGNORED;
                end else begin
                    case (phase_reg)
                        PH_HEAD: begin
                            if (in_item.rx_byte == head_byte) begin
                                store_en   = 1'b1;
                                wr_addr    = PW'(0);
                                phase_next = PH_ID;
                            end else begin
                                status = ST_BAD_HEAD;
                            end
                        end
                        PH_ID: begin
                            if (in_item.rx_byte == device_code) begin
                                store_en   = 1'b1;
                                wr_addr    = PW'(1);
                                phase_next = PH_LEN;
                                wpos_next  = PW'(2);
                            end else begin
                                phase_next = PH_HEAD;
                                status     = ST_BAD_ID;
                            end
                        end
                        PH_LEN: begin
                            if (len_total >= 9'(BUF_DEPTH) ||
                                in_item.rx_byte < MIN_LEN_BYTE) begin
                                phase_next = PH_HEAD;
                                wpos_next  = '0;
                                status     = ST_BAD_LEN;
                            end else begin
                                store_en   = 1'b1;
                                wr_addr    = PW'(2);
                                total_next = len_total[PW-1:0];
                                sum_next   = in_item.rx_byte;
                                wpos_next  = PW'(3);
                                phase_next = PH_BODY;
                            end
                        end
                        default: begin
                            store_en  = 1'b1;
                            wpos_next = pos_inc;
                            if (wpos_reg == PW'(3)) begin
                                code_next = in_item.rx_byte;
                            end
                            if (pos_inc >= total_reg) begin
                                // Last byte is the checksum
                                match_next = (sum_reg == in_item.rx_byte);
                                held_next  = 1'b1;
                                phase_next = PH_HEAD;
                                wpos_next  = '0;
                                status     = ST_COMPLETE;
                            end else begin
                                sum_next = sum_reg + in_item.rx_byte;
                            end
                        end
                    endcase
                end
            end
            MODE_RELEASE: begin
                held_next  = 1'b0;
                match_next = 1'b0;
                code_next  = '0;
            end
            default: ;
        endcase
    end

    assign wr_en   = accept && store_en;
    assign wr_data = in_item.rx_byte;

    // Read only inside the held frame
    assign idx_wide = IW'(in_item.read_index);
    assign rd_addr  = idx_wide[PW-1:0];
    assign rd_en    = accept && (in_item.mode == MODE_READ) && held_reg &&
                      (idx_wide < IW'(total_reg));

    // Report the state left by this transaction
    always_comb begin
        result               = '0;
        result.status        = status;
        result.frame_ready   = held_next;
        result.checksum_ok   = held_next && match_next;
        result.cmd_code      = held_next ? code_next : 8'd0;
        result.frame_length  = held_next ? 6'(total_next) : 6'd0;
    end

    // Hold parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEAD;
            wpos_reg  <= '0;
            total_reg <= '0;
            held_reg  <= 1'b0;
            sum_reg   <= '0;
            match_reg <= 1'b0;
            code_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            wpos_reg  <= wpos_next;
            total_reg <= total_next;
            held_reg  <= held_next;
            sum_reg   <= sum_next;
            match_reg <= match_next;
            code_reg  <= code_next;
        end
    end

endmodule

// File: sv/serial_command_frame_receiver.sv
// An accepted transaction's result is registered onto m_data for the next
// cycle. Throughput: one transaction per cycle while m_ready is high; the
// parser state and the store's registered read port update on accept.
// Reset: synchronous, active-low aresetn clears the parser and the output
// valid, and loads head_byte 0xFF and device_code 0xFC; the frame store
// is not cleared.
`include "serial_command_frame_receiver_assert.svh"

module serial_command_frame_receiver #(
    parameter int BUF_DEPTH = scfr_pkg::BUF_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  scfr_pkg::scfr_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output scfr_pkg::scfr_out_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                      cfg_data
);
    import scfr_pkg::*;

    localparam int PW = $clog2(BUF_DEPTH);

    logic            accept;
    logic [7:0]      head_byte_reg;
    logic [7:0]      device_code_reg;
    logic            m_valid_reg;
    scfr_out_t       result;
    scfr_out_t       result_reg;
    logic            wr_en;
    logic [PW-1:0]   wr_addr;
    logic [7:0]      wr_data;
    logic            rd_en;
    logic [PW-1:0]   rd_addr;
    logic [7:0]      rd_data;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_byte_reg   <= HEAD_BYTE_RST;
            device_code_reg <= DEVICE_CODE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_HEAD_BYTE:   head_byte_reg   <= cfg_data;
                REG_DEVICE_CODE: device_code_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    scfr_parser #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .in_item     (s_data),
        .head_byte   (head_byte_reg),
        .device_code (device_code_reg),
        .result      (result),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr)
    );

    scfr_store #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .accept  (accept),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output valid: load on accept, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result;
        end
    end

    // Merge read data from the store
    always_comb begin
        m_data           = result_reg;
        m_data.read_data = rd_data;
    end

    assign m_valid = m_valid_reg;

    `SCFR_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, accept, m_valid)
    `SCFR_ASSERT_NOW(a_idle_fields_zero, aclk, aresetn,
        m_valid && !m_data.frame_ready,
        m_data.frame_length == 6'd0 && m_data.cmd_code == 8'd0 && !m_data.checksum_ok)
    `SCFR_ASSERT_NOW(a_read_needs_hold, aclk, aresetn,
        m_valid && m_data.read_data != 8'd0, m_data.frame_ready)
    `SCFR_ASSERT_NOW(a_complete_holds, aclk, aresetn,
        m_valid && m_data.status == ST_COMPLETE, m_data.frame_ready)
    `SCFR_ASSERT_NOW(a_ignored_holds, aclk, aresetn,
        m_valid && m_data.status == ST_IGNORED, m_data.frame_ready)

endmodule
